// ===== rtl/core/mtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiword truncating multiplier package
// Shared codes, widths and control structures of the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mtm_pkg;

   localparam int unsigned LIMB_W = 32;
   localparam int unsigned PROD_W = 2 * LIMB_W;
   localparam int unsigned ACC_W  = PROD_W + 8;
   localparam int unsigned SIZE_W = 7;

   typedef enum logic [1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   localparam logic [1:0] REG_A_WORDS   = 2'd0;
   localparam logic [1:0] REG_B_WORDS   = 2'd1;
   localparam logic [1:0] REG_MAX_WORDS = 2'd2;
   localparam logic [1:0] REG_CARRY_IN  = 2'd3;

   typedef struct packed {
      logic valid;
      logic zero;
      logic col_last;
      logic job_last;
   } issue_type;

   typedef struct packed {
      logic wr_en;
      logic done;
      logic overflow;
   } wb_type;

endpackage

`default_nettype wire

// ===== rtl/core/mtm_if.sv =====
// ----------------------------------------------------------------------------
// Multiword truncating multiplier channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [3:0]  word_index;
   logic [31:0] word_value;

   modport source (output valid, action, word_index, word_value, input ready);
   modport sink (input valid, action, word_index, word_value, output ready);
endinterface

interface mtm_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  result_index;
   logic [31:0] result_word;
   logic [5:0]  result_count;
   logic        overflow;
   logic        last;

   modport source (output valid, result_index, result_word, result_count, overflow, last,
                   input ready);
   modport sink (input valid, result_index, result_word, result_count, overflow, last,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mtm_mac.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate column unit
// Registers one operand pair, multiplies it and adds the product into a
// column accumulator. At the end of a column the low word is written out
// and the rest carries into the next column.
// ----------------------------------------------------------------------------
`default_nettype none

module mtm_mac #(
   parameter int unsigned RESULT_WORDS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            carry_in,
   input  wire mtm_pkg::issue_type              issue,
   input  wire logic [mtm_pkg::LIMB_W-1:0]      a_word,
   input  wire logic [mtm_pkg::LIMB_W-1:0]      b_word,
   output mtm_pkg::wb_type                      wb,
   output logic [$clog2(RESULT_WORDS)-1:0]      wr_idx,
   output logic [mtm_pkg::LIMB_W-1:0]           wr_word
);

   localparam int unsigned RIDX_W = $clog2(RESULT_WORDS);

   mtm_pkg::issue_type                s1_ff;
   mtm_pkg::issue_type                s2_ff;
   logic [mtm_pkg::LIMB_W-1:0]        a_op_ff;
   logic [mtm_pkg::LIMB_W-1:0]        b_op_ff;
   logic [mtm_pkg::PROD_W-1:0]        prod_ff;
   logic [mtm_pkg::ACC_W-1:0]         acc_ff;
   logic [RIDX_W-1:0]                 col_ff;
   logic [mtm_pkg::ACC_W-1:0]         sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff <= issue.zero ? '0 : a_word;
      b_op_ff <= issue.zero ? '0 : b_word;
      prod_ff <= mtm_pkg::PROD_W'(a_op_ff) * mtm_pkg::PROD_W'(b_op_ff);
   end

   assign sum = acc_ff + mtm_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= mtm_pkg::ACC_W'(carry_in);
         col_ff <= '0;
      end else if (s2_ff.valid && s2_ff.col_last) begin
         acc_ff <= sum >> mtm_pkg::LIMB_W;
         col_ff <= col_ff + RIDX_W'(1);
      end else if (s2_ff.valid) begin
         acc_ff <= sum;
      end
   end

   assign wb.wr_en    = s2_ff.valid && s2_ff.col_last;
   assign wb.done     = s2_ff.valid && s2_ff.job_last;
   assign wb.overflow = (sum[mtm_pkg::ACC_W-1:mtm_pkg::LIMB_W] != '0);
   assign wr_idx      = col_ff;
   assign wr_word     = sum[mtm_pkg::LIMB_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/multiword_truncating_multiplier.sv =====
// ----------------------------------------------------------------------------
// Multiword truncating multiplier
// Schoolbook product of two operands of 32-bit words, truncated to a
// configurable number of result words, emitted low word first.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Role
//   req_ch       in          load A word, load B word or compute command
//   rsp_ch       out         one item per kept product word, low first
//   csr_*        in/out      APB-style register access, no wait states
//
// A compute item walks the product column by column with one 32x32
// multiplier: it issues each kept partial product and each empty top
// column, drains the operand and product registers of the pipeline, then
// emits the result words in turn (registered read of the result store).
// Reset clears control state and the registers; operand stores stay unset.
// The block is not ready while a compute item is in flight or being emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module multiword_truncating_multiplier #(
   parameter int unsigned OPERAND_WORDS = 16,
   parameter int unsigned RESULT_WORDS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mtm_req_if.sink          req_ch,
   mtm_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned SW     = mtm_pkg::SIZE_W;
   localparam int unsigned LW     = mtm_pkg::LIMB_W;
   localparam int unsigned OIDX_W = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
   localparam int unsigned RIDX_W = $clog2(RESULT_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] hi);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type           state_ff;
   logic [4:0]          a_words_ff;
   logic [4:0]          b_words_ff;
   logic [5:0]          max_words_ff;
   logic                carry_in_ff;

   logic [LW-1:0]       opa_mem [OPERAND_WORDS];
   logic [LW-1:0]       opb_mem [OPERAND_WORDS];
   logic [LW-1:0]       res_mem [RESULT_WORDS];

   logic [SW-1:0]       na_ff;
   logic [SW-1:0]       nb_ff;
   logic [SW-1:0]       cnt_ff;
   logic [SW-1:0]       col_ff;
   logic [SW-1:0]       i_ff;
   logic                start_ff;
   logic                ovf_ff;
   logic [SW-1:0]       emit_idx_ff;

   logic                rsp_valid_ff;
   logic [4:0]          rsp_index_ff;
   logic [LW-1:0]       rsp_word_ff;
   logic                rsp_last_ff;

   logic                csr_write;
   logic                req_accept;
   logic                compute_start;
   logic                load_ok;
   logic [SW-1:0]       load_idx;
   logic [SW-1:0]       na_in;
   logic [SW-1:0]       nb_in;
   logic [SW-1:0]       mx_in;
   logic [SW-1:0]       sum_in;
   logic [SW-1:0]       lo;
   logic [SW-1:0]       hi;
   logic                col_empty;
   logic [SW-1:0]       cur_i;
   logic [SW-1:0]       cur_j;
   logic                col_end;
   logic                job_end;
   mtm_pkg::issue_type  issue;
   mtm_pkg::wb_type     wb;
   logic [RIDX_W-1:0]   wr_idx;
   logic [LW-1:0]       wr_word;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_words_ff   <= 5'd1;
         b_words_ff   <= 5'd1;
         max_words_ff <= 6'd32;
         carry_in_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            mtm_pkg::REG_A_WORDS:   a_words_ff   <= csr_pwdata[4:0];
            mtm_pkg::REG_B_WORDS:   b_words_ff   <= csr_pwdata[4:0];
            mtm_pkg::REG_MAX_WORDS: max_words_ff <= csr_pwdata[5:0];
            mtm_pkg::REG_CARRY_IN:  carry_in_ff  <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         mtm_pkg::REG_A_WORDS:   csr_prdata = 32'(a_words_ff);
         mtm_pkg::REG_B_WORDS:   csr_prdata = 32'(b_words_ff);
         mtm_pkg::REG_MAX_WORDS: csr_prdata = 32'(max_words_ff);
         mtm_pkg::REG_CARRY_IN:  csr_prdata = 32'(carry_in_ff);
      endcase
   end

   // Request side.
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign compute_start = req_accept && (req_ch.action == mtm_pkg::ACT_COMPUTE);
   assign load_idx      = SW'(req_ch.word_index);
   assign load_ok       = req_accept && (load_idx < SW'(OPERAND_WORDS));

   always_ff @(posedge clock) begin
      if (load_ok && (req_ch.action == mtm_pkg::ACT_LOAD_A)) begin
         opa_mem[load_idx[OIDX_W-1:0]] <= req_ch.word_value;
      end
      if (load_ok && (req_ch.action == mtm_pkg::ACT_LOAD_B)) begin
         opb_mem[load_idx[OIDX_W-1:0]] <= req_ch.word_value;
      end
   end

   assign na_in  = clamp_size(SW'(a_words_ff), SW'(OPERAND_WORDS));
   assign nb_in  = clamp_size(SW'(b_words_ff), SW'(OPERAND_WORDS));
   assign mx_in  = clamp_size(SW'(max_words_ff), SW'(RESULT_WORDS));
   assign sum_in = na_in + nb_in;

   // Column sequencer: the partial products of column k have i from lo to hi.
   assign lo        = (col_ff >= nb_ff) ? (col_ff - nb_ff + SW'(1)) : '0;
   assign hi        = (col_ff < na_ff) ? col_ff : (na_ff - SW'(1));
   assign col_empty = (lo > hi);
   assign cur_i     = start_ff ? lo : i_ff;
   assign cur_j     = col_ff - cur_i;
   assign col_end   = col_empty || (cur_i == hi);
   assign job_end   = (col_ff == (cnt_ff - SW'(1)));

   assign issue.valid    = (state_ff == ST_RUN);
   assign issue.zero     = col_empty;
   assign issue.col_last = col_end;
   assign issue.job_last = col_end && job_end;

   mtm_mac #(
      .RESULT_WORDS (RESULT_WORDS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (compute_start),
      .carry_in (carry_in_ff),
      .issue    (issue),
      .a_word   (opa_mem[cur_i[OIDX_W-1:0]]),
      .b_word   (opb_mem[cur_j[OIDX_W-1:0]]),
      .wb       (wb),
      .wr_idx   (wr_idx),
      .wr_word  (wr_word)
   );

   always_ff @(posedge clock) begin
      if (wb.wr_en) begin
         res_mem[wr_idx] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (compute_start) begin
                  na_ff    <= na_in;
                  nb_ff    <= nb_in;
                  cnt_ff   <= (sum_in < mx_in) ? sum_in : mx_in;
                  col_ff   <= '0;
                  start_ff <= 1'b1;
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (col_end) begin
                  start_ff <= 1'b1;
                  if (job_end) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     col_ff <= col_ff + SW'(1);
                  end
               end else begin
                  i_ff     <= cur_i + SW'(1);
                  start_ff <= 1'b0;
               end
            end
            ST_DRAIN: begin
               if (wb.done) begin
                  ovf_ff      <= wb.overflow;
                  emit_idx_ff <= '0;
                  state_ff    <= ST_EMIT_RD;
               end
            end
            ST_EMIT_RD: begin
               rsp_word_ff  <= res_mem[emit_idx_ff[RIDX_W-1:0]];
               rsp_index_ff <= emit_idx_ff[4:0];
               rsp_last_ff  <= (emit_idx_ff == (cnt_ff - SW'(1)));
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  emit_idx_ff  <= emit_idx_ff + SW'(1);
                  state_ff     <= rsp_last_ff ? ST_IDLE : ST_EMIT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_index = rsp_index_ff;
   assign rsp_ch.result_word  = rsp_word_ff;
   assign rsp_ch.result_count = cnt_ff[5:0];
   assign rsp_ch.overflow     = ovf_ff;
   assign rsp_ch.last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mtm_checker.sv =====
// ----------------------------------------------------------------------------
// Multiword truncating multiplier checker
// Port-level properties of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_last,
   input wire logic [4:0] rsp_index,
   input wire logic [5:0] rsp_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
      else $error("Response item changed while stalled.");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Request side ready while a result item is pending.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_index + 5'd1) == rsp_count[4:0])
      else $error("Last result item does not match the word count.");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == mtm_pkg::ACT_COMPUTE) |=> !req_ready)
      else $error("Ready right after a compute item was accepted.");

   a_mid_job_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("Ready before the last result item was taken.");

endmodule

bind multiword_truncating_multiplier mtm_checker u_mtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_action (req_ch.action),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_last   (rsp_ch.last),
   .rsp_index  (rsp_ch.result_index),
   .rsp_count  (rsp_ch.result_count)
);

`default_nettype wire
